### rtl/gaussian_wasserstein_distance_2d_assert.svh
// Assertion macros for the Gaussian Wasserstein distance block
`ifndef GAUSSIAN_WASSERSTEIN_DISTANCE_2D_ASSERT_SVH
`define GAUSSIAN_WASSERSTEIN_DISTANCE_2D_ASSERT_SVH

// implication checked out of reset
`define GWD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked at every edge, reset included
`define GWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/gwd_pkg.sv
// Shared types and constants of the Gaussian Wasserstein distance block
package gwd_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int SQRT_LAT   = SQRT_STEPS + 1;
  localparam int LATENCY    = 2 * SQRT_LAT + 5;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NPSD = 2'd1;

  typedef struct packed {
    logic [49:0]        dsq;
    logic [25:0]        trsum;
    logic signed [50:0] tr12;
    logic               npsd;
  } side_t;

endpackage

### rtl/gwd_front.sv
// Front stages: products, mean difference, determinants and trace of C1*C2
module gwd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [23:0]   m1x,
  input  logic signed [23:0]   m1y,
  input  logic [23:0]          a1,
  input  logic signed [23:0]   b1,
  input  logic [23:0]          c1,
  input  logic signed [23:0]   m2x,
  input  logic signed [23:0]   m2y,
  input  logic [23:0]          a2,
  input  logic signed [23:0]   b2,
  input  logic [23:0]          c2,
  output logic                 out_valid,
  output gwd_pkg::side_t       out_side,
  output logic [63:0]          out_rad1,
  output logic [63:0]          out_rad2
);
  import gwd_pkg::*;

  logic               v1_r, v2_r;
  logic signed [24:0] dx_r, dy_r;
  logic [47:0]        ac1_r, ac2_r, aa_r, cc_r;
  logic signed [47:0] bb1_r, bb2_r, bb12_r;
  logic [25:0]        trsum1_r;
  logic signed [49:0] dx2, dy2;
  logic [48:0]        det1, det2;
  side_t              side_nxt, side_r;
  logic [63:0]        rad1_r, rad2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r     <= $signed({m1x[23], m1x}) - $signed({m2x[23], m2x});
    dy_r     <= $signed({m1y[23], m1y}) - $signed({m2y[23], m2y});
    ac1_r    <= a1 * c1;
    ac2_r    <= a2 * c2;
    aa_r     <= a1 * a2;
    cc_r     <= c1 * c2;
    bb1_r    <= b1 * b1;
    bb2_r    <= b2 * b2;
    bb12_r   <= b1 * b2;
    trsum1_r <= 26'(a1) + 26'(c1) + 26'(a2) + 26'(c2);
  end

  always_comb begin
    dx2  = dx_r * dx_r;
    dy2  = dy_r * dy_r;
    det1 = {1'b0, ac1_r} - {bb1_r[47], bb1_r};
    det2 = {1'b0, ac2_r} - {bb2_r[47], bb2_r};
    side_nxt.dsq   = 50'(dx2) + 50'(dy2);
    side_nxt.trsum = trsum1_r;
    side_nxt.tr12  = $signed({3'b0, aa_r} + {{2{bb12_r[47]}}, bb12_r, 1'b0} + {3'b0, cc_r});
    side_nxt.npsd  = det1[48] | det2[48];
  end

  always_ff @(posedge clk) begin
    side_r <= side_nxt;
    rad1_r <= {2'b0, det1[47:0], 14'b0};
    rad2_r <= {2'b0, det2[47:0], 14'b0};
  end

  assign out_valid = v2_r;
  assign out_side  = side_r;
  assign out_rad1  = rad1_r;
  assign out_rad2  = rad2_r;

endmodule

### rtl/gwd_isqrt.sv
// Pipelined floor square root, one result bit per stage, with side data
module gwd_isqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [63:0]     in_value,
  input  gwd_pkg::side_t  in_side,
  output logic            out_valid,
  output logic [31:0]     out_root,
  output gwd_pkg::side_t  out_side
);
  import gwd_pkg::*;

  logic        vld_r  [SQRT_STEPS+1];
  logic [63:0] rem_r  [SQRT_STEPS+1];
  logic [63:0] root_r [SQRT_STEPS+1];
  side_t       side_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= in_value;
    root_r[0] <= '0;
    side_r[0] <= in_side;
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [63:0] BIT = 64'(1) << (2 * (SQRT_STEPS - 1 - i));
    logic [63:0] trial;
    logic [63:0] rem_nxt, root_nxt;

    always_comb begin
      trial = root_r[i] + BIT;
      if (rem_r[i] >= trial) begin
        rem_nxt  = rem_r[i] - trial;
        root_nxt = (root_r[i] >> 1) + BIT;
      end else begin
        rem_nxt  = rem_r[i];
        root_nxt = root_r[i] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i+1]  <= rem_nxt;
      root_r[i+1] <= root_nxt;
      side_r[i+1] <= side_r[i];
    end
  end

  assign out_valid = vld_r[SQRT_STEPS];
  assign out_root  = root_r[SQRT_STEPS][31:0];
  assign out_side  = side_r[SQRT_STEPS];

endmodule

### rtl/gaussian_wasserstein_distance_2d.sv
// Each accepted request yields its result with a one-cycle out_valid strobe.
// Throughput: one request per cycle; busy stays low, every stage is a plain register.
// The path runs through two 32-stage square-root pipelines in series (determinants, then trace term).
// Reset (rst_n low, synchronous) clears all valid bits; data in flight is dropped.
// The receiver cannot stall, so no back-pressure exists anywhere in the pipeline.
module gaussian_wasserstein_distance_2d (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] in_first_mean_x,
  input  logic signed [23:0] in_first_mean_y,
  input  logic [23:0]        in_first_var_x,
  input  logic signed [23:0] in_first_cov_xy,
  input  logic [23:0]        in_first_var_y,
  input  logic signed [23:0] in_second_mean_x,
  input  logic signed [23:0] in_second_mean_y,
  input  logic [23:0]        in_second_var_x,
  input  logic signed [23:0] in_second_cov_xy,
  input  logic [23:0]        in_second_var_y,
  output logic               out_valid,
  output logic [63:0]        out_distance,
  output logic [1:0]         out_status
);
  import gwd_pkg::*;

  logic               fr_valid;
  side_t              fr_side;
  logic [63:0]        fr_rad1, fr_rad2;
  logic               sq1_valid, sq2_valid, sq3_valid;
  logic [31:0]        sq1_root, sq2_root, sq3_root;
  side_t              sq1_side, sq3_side;
  logic               v3_r, v4_r, v5_r;
  logic [61:0]        prod_r;
  side_t              side3_r, side4_r;
  logic signed [51:0] inner;
  logic [63:0]        rad3_r;
  logic signed [51:0] total;
  logic [63:0]        dist_r;
  logic [1:0]         status_r;

  assign busy = 1'b0;

  gwd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .m1x       (in_first_mean_x),
    .m1y       (in_first_mean_y),
    .a1        (in_first_var_x),
    .b1        (in_first_cov_xy),
    .c1        (in_first_var_y),
    .m2x       (in_second_mean_x),
    .m2y       (in_second_mean_y),
    .a2        (in_second_var_x),
    .b2        (in_second_cov_xy),
    .c2        (in_second_var_y),
    .out_valid (fr_valid),
    .out_side  (fr_side),
    .out_rad1  (fr_rad1),
    .out_rad2  (fr_rad2)
  );

  gwd_isqrt u_sqrt_det1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_value  (fr_rad1),
    .in_side   (fr_side),
    .out_valid (sq1_valid),
    .out_root  (sq1_root),
    .out_side  (sq1_side)
  );

  gwd_isqrt u_sqrt_det2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_value  (fr_rad2),
    .in_side   ('0),
    .out_valid (sq2_valid),
    .out_root  (sq2_root),
    .out_side  ()
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v3_r <= sq1_valid & sq2_valid;
      v4_r <= v3_r;
      v5_r <= sq3_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= sq1_root[30:0] * sq2_root[30:0];
    side3_r <= sq1_side;
  end

  // sqrt(det1*det2) in Q24.24 joins tr(C1*C2); a non-PSD pair drops the root term
  always_comb begin
    inner = $signed({side3_r.tr12[50], side3_r.tr12}) + $signed({3'b0, prod_r[61:14], 1'b0});
  end

  always_ff @(posedge clk) begin
    side4_r <= side3_r;
    if (!side3_r.npsd && !inner[51] && inner != '0) begin
      rad3_r <= {2'b0, inner[49:0], 12'b0};
    end else begin
      rad3_r <= '0;
    end
  end

  gwd_isqrt u_sqrt_trace (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_value  (rad3_r),
    .in_side   (side4_r),
    .out_valid (sq3_valid),
    .out_root  (sq3_root),
    .out_side  (sq3_side)
  );

  always_comb begin
    total = $signed({2'b0, sq3_side.dsq}) + $signed({14'b0, sq3_side.trsum, 12'b0})
          - $signed({14'b0, sq3_root[30:0], 7'b0});
  end

  // clamp a truncation-induced negative total to zero
  always_ff @(posedge clk) begin
    dist_r   <= total[51] ? '0 : {12'b0, total};
    status_r <= sq3_side.npsd ? STATUS_NPSD : STATUS_OK;
  end

  assign out_valid    = v5_r;
  assign out_distance = dist_r;
  assign out_status   = status_r;

endmodule

### rtl/gwd_checker.sv
// Port-level checker for the Gaussian Wasserstein distance block, with its bind
`include "gaussian_wasserstein_distance_2d_assert.svh"

module gwd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status
);
  import gwd_pkg::*;

  `GWD_ASSERT_IMPLY(a_result_follows, start && !busy, ##LATENCY out_valid, "request lost")
  `GWD_ASSERT_IMPLY(a_no_spurious, out_valid, $past(start && !busy, LATENCY), "unrequested result")
  `GWD_ASSERT_IMPLY(a_status_code, out_valid, out_status == STATUS_OK || out_status == STATUS_NPSD, "bad status")
  `GWD_ASSERT_NEXT(a_reset_quiet, !rst_n, !out_valid, "result during reset")

endmodule

bind gaussian_wasserstein_distance_2d gwd_checker u_gwd_checker (.*);
